[hdl/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, control word and status types, and the microcode ROM
// of the scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Gain is unsigned with one integer bit, 0.0 .. 1.0
  localparam int GAIN_W = FRAC_BITS + 1;
  // Multiplier: (DATA_WIDTH+1)-bit operand times gain
  localparam int PROD_W = DATA_WIDTH + 1 + GAIN_W;
  // Divide iteration counter, counts 0 .. FRAC_BITS + 1
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // 0.0001 rounded to nearest, at least one LSB
  localparam int unsigned BIAS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int unsigned BIAS     = (BIAS_RAW == 0) ? 1 : BIAS_RAW;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE = 1'b1;

  localparam logic [DATA_WIDTH-1:0] INIT_ESTIMATE_RST = '0;
  localparam logic [DATA_WIDTH-1:0] INIT_VARIANCE_RST = DATA_WIDTH'(1 << FRAC_BITS);

  // Micro-operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_ACCEPT  = 3'd0;
  localparam logic [OP_W-1:0] OP_BIAS    = 3'd1;
  localparam logic [OP_W-1:0] OP_SETUP   = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV     = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL_X   = 3'd4;
  localparam logic [OP_W-1:0] OP_MUL_P   = 3'd5;
  localparam logic [OP_W-1:0] OP_EMIT    = 3'd6;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd7;

  // Sequencing conditions
  localparam int CND_W = 2;
  localparam logic [CND_W-1:0] CND_NEXT     = 2'd0;
  localparam logic [CND_W-1:0] CND_ALWAYS   = 2'd1;
  localparam logic [CND_W-1:0] CND_RESTART  = 2'd2;
  localparam logic [CND_W-1:0] CND_DIV_MORE = 2'd3;

  // Program step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] S_IDLE    = 3'd0;
  localparam logic [STEP_W-1:0] S_BIAS    = 3'd1;
  localparam logic [STEP_W-1:0] S_SETUP   = 3'd2;
  localparam logic [STEP_W-1:0] S_DIV     = 3'd3;
  localparam logic [STEP_W-1:0] S_MUL_X   = 3'd4;
  localparam logic [STEP_W-1:0] S_MUL_P   = 3'd5;
  localparam logic [STEP_W-1:0] S_EMIT    = 3'd6;
  localparam logic [STEP_W-1:0] S_RESTART = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CND_W-1:0]  cond;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic stall;     // hold the current step
    logic restart;   // command bit of the offered input beat
    logic div_more;  // divide iterations remain
  } dp_status_t;

  function automatic ctl_word_t micro_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    case (step)
      S_IDLE:    w = '{op: OP_ACCEPT,  cond: CND_RESTART,  target: S_RESTART};
      S_BIAS:    w = '{op: OP_BIAS,    cond: CND_NEXT,     target: S_IDLE};
      S_SETUP:   w = '{op: OP_SETUP,   cond: CND_NEXT,     target: S_IDLE};
      S_DIV:     w = '{op: OP_DIV,     cond: CND_DIV_MORE, target: S_DIV};
      S_MUL_X:   w = '{op: OP_MUL_X,   cond: CND_NEXT,     target: S_IDLE};
      S_MUL_P:   w = '{op: OP_MUL_P,   cond: CND_NEXT,     target: S_IDLE};
      S_EMIT:    w = '{op: OP_EMIT,    cond: CND_ALWAYS,   target: S_IDLE};
      S_RESTART: w = '{op: OP_RESTART, cond: CND_ALWAYS,   target: S_IDLE};
      default:   w = '{op: OP_ACCEPT,  cond: CND_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/skf_if.sv]
// ----------------------------------------------------------------------------
// skf_if
// Valid/ready channel interfaces: input items, results, configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [skf_pkg::DATA_WIDTH-1:0] measurement;
  logic [skf_pkg::DATA_WIDTH-1:0]       measurement_variance;

  modport source (output valid, command, measurement, measurement_variance,
                  input ready);
  modport sink   (input valid, command, measurement, measurement_variance,
                  output ready);
endinterface

interface skf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [skf_pkg::DATA_WIDTH-1:0] estimate;
  logic [skf_pkg::DATA_WIDTH-1:0]       error_variance;

  modport source (output valid, estimate, error_variance, input ready);
  modport sink   (input valid, estimate, error_variance, output ready);
endinterface

interface skf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [skf_pkg::CFG_IDX_W-1:0]       index;
  logic [skf_pkg::DATA_WIDTH-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/skf_seq.sv]
// ----------------------------------------------------------------------------
// skf_seq
// Step counter and microcode ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire skf_pkg::dp_status_t   status,
  output skf_pkg::ctl_word_t         ctl
);

  logic [skf_pkg::STEP_W-1:0] step_r;
  logic [skf_pkg::STEP_W-1:0] step_nxt;
  logic [skf_pkg::STEP_W-1:0] step_inc;

  assign ctl      = skf_pkg::micro_rom(step_r);
  assign step_inc = step_r + skf_pkg::STEP_W'(1);

  always_comb begin
    if (status.stall) begin
      step_nxt = step_r;
    end else begin
      case (ctl.cond)
        skf_pkg::CND_NEXT:     step_nxt = step_inc;
        skf_pkg::CND_ALWAYS:   step_nxt = ctl.target;
        skf_pkg::CND_RESTART:  step_nxt = status.restart ? ctl.target : step_inc;
        skf_pkg::CND_DIV_MORE: step_nxt = status.div_more ? ctl.target : step_inc;
        default:               step_nxt = skf_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= skf_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // divide loop exits straight into the first multiply
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == skf_pkg::S_DIV && !status.div_more) |=> (step_r == skf_pkg::S_MUL_X))
    else $error("divide loop exit went astray");

endmodule

`default_nettype wire

[hdl/skf_dp.sv]
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: state registers, restoring divider, shared multiplier,
// input capture and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire skf_pkg::ctl_word_t              ctl,
  output skf_pkg::dp_status_t                  status,
  input  wire logic [skf_pkg::DATA_WIDTH-1:0]  init_est,
  input  wire logic [skf_pkg::DATA_WIDTH-1:0]  init_var,
  skf_in_if.sink                               in_ch,
  skf_out_if.source                            out_ch
);

  localparam int DW = skf_pkg::DATA_WIDTH;
  localparam int FB = skf_pkg::FRAC_BITS;
  localparam int GW = skf_pkg::GAIN_W;
  localparam int PW = skf_pkg::PROD_W;

  // state
  logic [DW-1:0]   x_r;
  logic [DW-1:0]   p_r;
  // working registers
  logic [DW-1:0]   z_r;
  logic [DW-1:0]   r_r;
  logic [DW-1:0]   pb_r;
  logic [DW:0]     den_r;
  logic [DW+1:0]   rem_r;
  logic [GW-1:0]   q_r;
  logic [DW:0]     mag_r;
  logic            neg_r;
  logic [PW-1:0]   prod_r;
  logic [skf_pkg::CNT_W-1:0] div_cnt_r;
  // output register
  logic            out_valid_r;
  logic [DW-1:0]   out_est_r;
  logic [DW-1:0]   out_var_r;

  logic [DW:0]     pb_sum;
  logic [DW-1:0]   pb_sat;
  logic [DW:0]     diff;
  logic [DW:0]     mag;
  logic [DW:0]     den_sum;
  logic            rem_ge;
  logic [DW+1:0]   rem_sub;
  logic [DW:0]     mul_a;
  logic [GW-1:0]   mul_b;
  logic [PW-1:0]   mul_p;
  logic [DW+1:0]   delta;
  logic [DW+1:0]   x_ext;
  logic [DW+1:0]   x_new;
  logic [DW-1:0]   p_new;
  logic            out_busy;
  logic            accept;

  assign in_ch.ready      = (ctl.op == skf_pkg::OP_ACCEPT);
  assign accept           = in_ch.ready && in_ch.valid;
  assign out_busy         = out_valid_r && !out_ch.ready;

  assign status.stall     = (ctl.op == skf_pkg::OP_ACCEPT && !in_ch.valid) ||
                            (ctl.op == skf_pkg::OP_EMIT && out_busy);
  assign status.restart   = in_ch.command;
  assign status.div_more  = (div_cnt_r != skf_pkg::CNT_W'(FB));

  assign out_ch.valid          = out_valid_r;
  assign out_ch.estimate       = out_est_r;
  assign out_ch.error_variance = out_var_r;

  // P + bias, saturating
  assign pb_sum  = {1'b0, p_r} + (DW+1)'(skf_pkg::BIAS);
  assign pb_sat  = pb_sum[DW] ? {DW{1'b1}} : pb_sum[DW-1:0];

  // innovation z - x as sign and magnitude
  assign diff    = {z_r[DW-1], z_r} - {x_r[DW-1], x_r};
  assign mag     = diff[DW] ? (~diff + (DW+1)'(1)) : diff;

  assign den_sum = {1'b0, pb_r} + {1'b0, r_r};

  // one restoring divide step
  assign rem_ge  = (rem_r >= {1'b0, den_r});
  assign rem_sub = rem_ge ? (rem_r - {1'b0, den_r}) : rem_r;

  // shared multiplier: gain*|z-x| then (1-gain)*Pb
  assign mul_a   = (ctl.op == skf_pkg::OP_MUL_X) ? mag_r : {1'b0, pb_r};
  assign mul_b   = (ctl.op == skf_pkg::OP_MUL_X) ? q_r : (skf_pkg::GAIN_ONE - q_r);
  assign mul_p   = PW'(mul_a) * PW'(mul_b);

  assign delta   = prod_r[PW-1:FB];
  assign x_ext   = {{2{x_r[DW-1]}}, x_r};
  assign x_new   = neg_r ? (x_ext - delta) : (x_ext + delta);
  assign p_new   = (|prod_r[PW-1:FB+DW]) ? {DW{1'b1}} : prod_r[FB+DW-1:FB];

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= skf_pkg::INIT_ESTIMATE_RST;
      p_r         <= skf_pkg::INIT_VARIANCE_RST;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (ctl.op == skf_pkg::OP_EMIT && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.op)
        skf_pkg::OP_SETUP: begin
          div_cnt_r <= '0;
        end
        skf_pkg::OP_DIV: begin
          div_cnt_r <= div_cnt_r + skf_pkg::CNT_W'(1);
        end
        skf_pkg::OP_MUL_P: begin
          x_r <= x_new[DW-1:0];
        end
        skf_pkg::OP_EMIT: begin
          if (!out_busy) begin
            p_r <= p_new;
          end
        end
        skf_pkg::OP_RESTART: begin
          x_r <= init_est;
          p_r <= init_var;
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (ctl.op)
      skf_pkg::OP_ACCEPT: begin
        if (accept) begin
          z_r <= in_ch.measurement;
          r_r <= in_ch.measurement_variance;
        end
      end
      skf_pkg::OP_BIAS: begin
        pb_r  <= pb_sat;
        mag_r <= mag;
        neg_r <= diff[DW];
      end
      skf_pkg::OP_SETUP: begin
        den_r <= den_sum;
        rem_r <= {2'b00, pb_r};
        q_r   <= '0;
      end
      skf_pkg::OP_DIV: begin
        rem_r <= {rem_sub[DW:0], 1'b0};
        q_r   <= {q_r[GW-2:0], rem_ge};
      end
      skf_pkg::OP_MUL_X: begin
        prod_r <= mul_p;
      end
      skf_pkg::OP_MUL_P: begin
        prod_r <= mul_p;
      end
      skf_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_est_r <= x_r;
          out_var_r <= p_new;
        end
      end
      default: begin
      end
    endcase
  end

  // gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == skf_pkg::OP_MUL_X) |-> (q_r <= skf_pkg::GAIN_ONE))
    else $error("gain above one");

  // remainder stays below twice the divisor while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == skf_pkg::OP_DIV) |-> (rem_r < {den_r, 1'b0}))
    else $error("divide remainder out of bound");

  // updated variance cannot exceed P + bias
  a_var_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == skf_pkg::OP_EMIT) |-> (prod_r[PW-1:FB] <= {2'b00, pb_r}))
    else $error("variance grew past P + bias");

endmodule

`default_nettype wire

[hdl/scalar_kalman_filter.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// Scalar Kalman filter, Q16.16, driven by a microcoded sequencer.
//
// Channels: in_ch takes items {command, measurement, measurement_variance};
// command 0 runs one filter update and produces one out_ch beat
// {estimate, error_variance}; command 1 reloads the estimate and variance
// from the configuration registers and produces nothing. cfg_ch writes
// register 0 (initial estimate) or 1 (initial variance); always ready.
// An update runs bias and setup, 17 restoring divide steps for the gain, two
// multiply steps on the shared multiplier and the output step. A new item is
// accepted only after the previous one has run all its steps, a restart item
// its reload step. The divide loop makes up most of an update's steps.
// Results sit in an output register; the next item is accepted while a
// result waits, and the sequencer holds at its output step only if the
// previous result is still not taken. Reset loads estimate 0, variance 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter (
  input  wire logic clk,
  input  wire logic rst_n,
  skf_in_if.sink    in_ch,
  skf_out_if.source out_ch,
  skf_cfg_if.sink   cfg_ch
);

  logic [skf_pkg::DATA_WIDTH-1:0] init_est_r;
  logic [skf_pkg::DATA_WIDTH-1:0] init_var_r;
  skf_pkg::ctl_word_t             ctl;
  skf_pkg::dp_status_t            status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_est_r <= skf_pkg::INIT_ESTIMATE_RST;
      init_var_r <= skf_pkg::INIT_VARIANCE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        skf_pkg::REG_INIT_ESTIMATE: init_est_r <= cfg_ch.data;
        skf_pkg::REG_INIT_VARIANCE: init_var_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  skf_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  skf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .status   (status),
    .init_est (init_est_r),
    .init_var (init_var_r),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
